// File: hdl/tmpr_pkg.sv
// shared types and constants for the touch mask to point report mapper
// no dependencies; used by every module of the block
package tmpr_pkg;

    // default configuration
    localparam int CHANNELS_DEF  = 34;
    localparam int COORD_MAX_DEF = 32767;

    // widest channel count the job format can carry
    localparam int CH_MAX = 64;

    // field widths fixed by the interface
    localparam int CHAN_W  = 6;
    localparam int COORD_W = 15;
    localparam int IN_W    = 16;

    // job queue between front and back
    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = 1;
    localparam int Q_CNT_W = 2;

    typedef enum logic [1:0] {
        JOB_LOAD   = 2'd0,
        JOB_SCAN   = 2'd1,
        JOB_RELALL = 2'd2
    } t_job_kind;

    typedef enum logic {
        REP_POINT = 1'b0,
        REP_ALL   = 1'b1
    } t_report_kind;

    typedef enum logic {
        BK_IDLE = 1'b0,
        BK_WALK = 1'b1
    } t_back_state;

    typedef struct packed {
        t_job_kind           kind;
        logic [CHAN_W-1:0]   channel;
        logic [COORD_W-1:0]  x;
        logic [COORD_W-1:0]  y;
        logic [CH_MAX-1:0]   changed;
        logic [CH_MAX-1:0]   want;
    } t_job;

endpackage

// File: hdl/tmpr_queue.sv
// two-entry job queue between the front and the back part
// depends on tmpr_pkg
module tmpr_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  tmpr_pkg::t_job i_job,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_vld,
    output tmpr_pkg::t_job o_job
);

    tmpr_pkg::t_job                r_ents [tmpr_pkg::Q_DEPTH];
    logic [tmpr_pkg::Q_PTR_W-1:0]  r_wptr;
    logic [tmpr_pkg::Q_PTR_W-1:0]  r_rptr;
    logic [tmpr_pkg::Q_CNT_W-1:0]  r_cnt;
    logic [tmpr_pkg::Q_CNT_W-1:0]  n_cnt;

    assign o_full = (r_cnt == tmpr_pkg::Q_CNT_W'(tmpr_pkg::Q_DEPTH));
    assign o_vld  = (r_cnt != '0);
    assign o_job  = r_ents[r_rptr];

    always_comb begin
        n_cnt = r_cnt;
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (!i_push && i_pop) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            r_cnt <= n_cnt;
            if (i_push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (i_pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_ents[r_wptr] <= i_job;
        end
    end

    // overflow and underflow
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (!o_full || i_pop))
        else $error("job queue overflow");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_vld)
        else $error("job queue underflow");

endmodule

// File: hdl/tmpr_front.sv
// front part: accepts items, keeps enable bits, held mask and mode,
// classifies each item into a job for the back part; depends on tmpr_pkg
module tmpr_front #(
    parameter int CHANNELS  = tmpr_pkg::CHANNELS_DEF,
    parameter int COORD_MAX = tmpr_pkg::COORD_MAX_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_accept,
    input  logic                          i_op,
    input  logic [tmpr_pkg::CHAN_W-1:0]   i_channel,
    input  logic                          i_point_enabled,
    input  logic [tmpr_pkg::IN_W-1:0]     i_x_in,
    input  logic [tmpr_pkg::IN_W-1:0]     i_y_in,
    input  logic [CHANNELS-1:0]           i_touch_mask,
    input  logic                          i_trusted,
    input  logic                          i_cfg_wr,
    input  logic                          i_cfg_data,
    output logic                          o_push,
    output tmpr_pkg::t_job                o_job
);

    localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    logic                 r_hid;
    logic [CHANNELS-1:0]  r_held;
    logic [CHANNELS-1:0]  n_held;
    logic [CHANNELS-1:0]  r_en;
    logic [CHANNELS-1:0]  n_en;
    logic [CHANNELS-1:0]  want;
    logic [CHANNELS-1:0]  changed;
    logic                 chan_ok;

    function automatic logic [tmpr_pkg::COORD_W-1:0] sat(input logic [tmpr_pkg::IN_W-1:0] v);
        logic [tmpr_pkg::IN_W-1:0] c;
        c = (v > tmpr_pkg::IN_W'(COORD_MAX)) ? tmpr_pkg::IN_W'(COORD_MAX) : v;
        return c[tmpr_pkg::COORD_W-1:0];
    endfunction

    assign want    = i_touch_mask & r_en;
    assign changed = want ^ r_held;
    assign chan_ok = ({1'b0, i_channel} < (tmpr_pkg::CHAN_W + 1)'(CHANNELS));

    always_comb begin
        o_push         = 1'b0;
        o_job.kind     = tmpr_pkg::JOB_LOAD;
        o_job.channel  = i_channel;
        o_job.x        = sat(i_x_in);
        o_job.y        = sat(i_y_in);
        o_job.changed  = '0;
        o_job.want     = '0;
        o_job.changed[CHANNELS-1:0] = changed;
        o_job.want[CHANNELS-1:0]    = want;
        n_held = r_held;
        n_en   = r_en;
        if (i_accept) begin
            if (!i_op) begin
                // table load, out of range channels dropped
                if (chan_ok) begin
                    o_push = 1'b1;
                    n_en[i_channel[IDX_W-1:0]] = i_point_enabled;
                end
            end else if (r_hid) begin
                if (!i_trusted) begin
                    if (r_held != '0) begin
                        o_push     = 1'b1;
                        o_job.kind = tmpr_pkg::JOB_RELALL;
                        n_held     = '0;
                    end
                end else if (changed != '0) begin
                    o_push     = 1'b1;
                    o_job.kind = tmpr_pkg::JOB_SCAN;
                    n_held     = want;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hid  <= 1'b0;
            r_held <= '0;
            r_en   <= '0;
        end else begin
            r_held <= n_held;
            r_en   <= n_en;
            if (i_cfg_wr) begin
                r_hid <= i_cfg_data;
            end
        end
    end

endmodule

// File: hdl/tmpr_back.sv
// back part: coordinate memory, channel walk and report output register
// depends on tmpr_pkg
module tmpr_back #(
    parameter int CHANNELS = tmpr_pkg::CHANNELS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_job_vld,
    input  tmpr_pkg::t_job                 i_job,
    output logic                           o_pop,
    output logic                           o_strobe,
    output logic                           o_report_kind,
    output logic [tmpr_pkg::CHAN_W-1:0]    o_point_id,
    output logic                           o_pressed,
    output logic [tmpr_pkg::COORD_W-1:0]   o_x_out,
    output logic [tmpr_pkg::COORD_W-1:0]   o_y_out,
    output logic                           o_last
);

    localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int ENT_W = 2 * tmpr_pkg::COORD_W;

    tmpr_pkg::t_back_state   r_state;
    tmpr_pkg::t_back_state   n_state;
    logic [IDX_W-1:0]        r_idx;
    logic [IDX_W-1:0]        n_idx;
    logic [CHANNELS-1:0]     r_pend;
    logic [CHANNELS-1:0]     n_pend;
    logic [CHANNELS-1:0]     r_want;
    logic [CHANNELS-1:0]     n_want;
    logic [CHANNELS-1:0]     pend_sh;
    logic [tmpr_pkg::CHAN_W:0] id_full;

    logic [ENT_W-1:0]        r_mem [CHANNELS];
    logic [CHANNELS-1:0]     r_mem_vld;
    logic [ENT_W-1:0]        r_rd;
    logic                    r_rd_vld;
    logic                    mem_we;

    logic                           r_out_vld;
    logic                           n_out_vld;
    tmpr_pkg::t_report_kind         r_out_kind;
    tmpr_pkg::t_report_kind         n_out_kind;
    logic [tmpr_pkg::CHAN_W-1:0]    r_out_id;
    logic [tmpr_pkg::CHAN_W-1:0]    n_out_id;
    logic                           r_out_pressed;
    logic                           n_out_pressed;
    logic                           r_out_last;
    logic                           n_out_last;

    assign pend_sh = r_pend >> 1;
    assign id_full = (tmpr_pkg::CHAN_W + 1)'(r_idx) + 1'b1;

    always_comb begin
        n_state       = r_state;
        n_idx         = r_idx;
        n_pend        = r_pend;
        n_want        = r_want;
        o_pop         = 1'b0;
        mem_we        = 1'b0;
        n_out_vld     = 1'b0;
        n_out_kind    = tmpr_pkg::REP_POINT;
        n_out_id      = r_out_id;
        n_out_pressed = 1'b0;
        n_out_last    = 1'b0;
        unique case (r_state)
            tmpr_pkg::BK_IDLE: begin
                if (i_job_vld) begin
                    o_pop = 1'b1;
                    unique case (i_job.kind)
                        tmpr_pkg::JOB_LOAD: begin
                            mem_we = 1'b1;
                        end
                        tmpr_pkg::JOB_RELALL: begin
                            n_out_vld  = 1'b1;
                            n_out_kind = tmpr_pkg::REP_ALL;
                            n_out_id   = '0;
                            n_out_last = 1'b1;
                        end
                        tmpr_pkg::JOB_SCAN: begin
                            n_pend  = i_job.changed[CHANNELS-1:0];
                            n_want  = i_job.want[CHANNELS-1:0];
                            n_idx   = '0;
                            n_state = tmpr_pkg::BK_WALK;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            tmpr_pkg::BK_WALK: begin
                n_out_vld     = r_pend[0];
                n_out_pressed = r_want[0];
                n_out_id      = id_full[tmpr_pkg::CHAN_W-1:0];
                n_out_last    = (pend_sh == '0);
                n_pend        = pend_sh;
                n_want        = r_want >> 1;
                n_idx         = r_idx + 1'b1;
                if (pend_sh == '0) begin
                    n_state = tmpr_pkg::BK_IDLE;
                end
            end
            default: begin
                n_state = tmpr_pkg::BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= tmpr_pkg::BK_IDLE;
            r_out_vld <= 1'b0;
            r_mem_vld <= '0;
        end else begin
            r_state   <= n_state;
            r_out_vld <= n_out_vld;
            if (mem_we) begin
                r_mem_vld[i_job.channel[IDX_W-1:0]] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx         <= n_idx;
        r_pend        <= n_pend;
        r_want        <= n_want;
        r_out_kind    <= n_out_kind;
        r_out_id      <= n_out_id;
        r_out_pressed <= n_out_pressed;
        r_out_last    <= n_out_last;
    end

    // coordinate memory, registered read at the walk index
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[i_job.channel[IDX_W-1:0]] <= {i_job.x, i_job.y};
        end
        r_rd     <= r_mem[r_idx];
        r_rd_vld <= r_mem_vld[r_idx];
    end

    assign o_strobe      = r_out_vld;
    assign o_report_kind = r_out_kind;
    assign o_point_id    = r_out_id;
    assign o_pressed     = r_out_pressed;
    assign o_last        = r_out_last;
    assign o_x_out = (r_out_pressed && r_rd_vld) ? r_rd[ENT_W-1:tmpr_pkg::COORD_W] : '0;
    assign o_y_out = (r_out_pressed && r_rd_vld) ? r_rd[tmpr_pkg::COORD_W-1:0] : '0;

    // a walk always has a changed channel left
    a_walk_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == tmpr_pkg::BK_WALK) |-> (r_pend != '0))
        else $error("walk with no pending channel");

    // release-all is a lone, final report with id zero
    a_relall_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && (r_out_kind == tmpr_pkg::REP_ALL))
            |-> (r_out_last && (r_out_id == '0) && !r_out_pressed))
        else $error("malformed release-all report");

endmodule

// File: hdl/touch_mask_to_point_report_mapper_core.sv
// top level of the touch mask to point report mapper
// depends on tmpr_pkg, tmpr_front, tmpr_queue and tmpr_back
//
// Items enter on start while busy is low: a load writes one channel's enable
// bit and saturated coordinates; a scan, in hid mode, compares the enabled
// touch mask with the points held and reports every change, or releases all
// held points when untrusted. Results leave on o_strobe, one report a cycle,
// and cannot be held off: the receiver must take every beat.
// The front part accepts one item a cycle while the two-entry job queue has
// room; busy is simply that queue being full. The back part sets the rate:
// it takes a load or a release-all as it pops it in the idle state, and a
// scan starts there and then walks each channel up to and including its
// highest changed channel. Within a scan the walk over channels, one channel
// a cycle through the coordinate memory read port, is what paces the
// reports. Loads go through the same queue, so table updates and scans stay
// in order. The hid_mode register is written on its own channel, which is
// always ready; write it only while no scan is in flight.
module touch_mask_to_point_report_mapper_core #(
    parameter int CHANNELS  = tmpr_pkg::CHANNELS_DEF,
    parameter int COORD_MAX = tmpr_pkg::COORD_MAX_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // command side
    input  logic                           start,
    output logic                           busy,
    input  logic                           i_op,
    input  logic [tmpr_pkg::CHAN_W-1:0]    i_channel,
    input  logic                           i_point_enabled,
    input  logic [tmpr_pkg::IN_W-1:0]      i_x_in,
    input  logic [tmpr_pkg::IN_W-1:0]      i_y_in,
    input  logic [CHANNELS-1:0]            i_touch_mask,
    input  logic                           i_trusted,
    // configuration write channel (hid_mode)
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic                           i_cfg_data,
    // report side, one beat per strobe
    output logic                           o_strobe,
    output logic                           o_report_kind,
    output logic [tmpr_pkg::CHAN_W-1:0]    o_point_id,
    output logic                           o_pressed,
    output logic [tmpr_pkg::COORD_W-1:0]   o_x_out,
    output logic [tmpr_pkg::COORD_W-1:0]   o_y_out,
    output logic                           o_last
);

    logic            accept;
    logic            push;
    logic            pop;
    logic            q_full;
    logic            q_vld;
    tmpr_pkg::t_job  front_job;
    tmpr_pkg::t_job  head_job;

    // the register channel never stalls
    assign o_cfg_ready = 1'b1;

    assign busy   = q_full;
    assign accept = start && !busy;

    // classify items, keep enable bits, held mask and mode
    tmpr_front #(
        .CHANNELS  (CHANNELS),
        .COORD_MAX (COORD_MAX)
    ) u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_accept        (accept),
        .i_op            (i_op),
        .i_channel       (i_channel),
        .i_point_enabled (i_point_enabled),
        .i_x_in          (i_x_in),
        .i_y_in          (i_y_in),
        .i_touch_mask    (i_touch_mask),
        .i_trusted       (i_trusted),
        .i_cfg_wr        (i_cfg_valid && o_cfg_ready),
        .i_cfg_data      (i_cfg_data),
        .o_push          (push),
        .o_job           (front_job)
    );

    // jobs wait here while the back part walks a scan
    tmpr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (front_job),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_vld   (q_vld),
        .o_job   (head_job)
    );

    // coordinate table, channel walk and report register
    tmpr_back #(
        .CHANNELS (CHANNELS)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_job_vld     (q_vld),
        .i_job         (head_job),
        .o_pop         (pop),
        .o_strobe      (o_strobe),
        .o_report_kind (o_report_kind),
        .o_point_id    (o_point_id),
        .o_pressed     (o_pressed),
        .o_x_out       (o_x_out),
        .o_y_out       (o_y_out),
        .o_last        (o_last)
    );

endmodule
